@@ design/swmrd_pkg.sv @@
package swmrd_pkg;

  localparam int unsigned DIST_W  = 32;
  localparam int unsigned COST_W  = 20;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  // station entry queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // register indexes (paddr[2])
  localparam logic REG_TANK_RANGE  = 1'b0;
  localparam logic REG_ROAD_LENGTH = 1'b1;

  typedef struct packed {
    logic [DIST_W-1:0] position;
    logic [COST_W-1:0] cost;
    logic              last;
    logic              near_start;  // within tank range of the start
    logic              near_end;    // within tank range of the road end
  } item_t;

endpackage

@@ design/sliding_window_min_refuel_dp.sv @@
// Least total stop cost to reach the road end with a fixed tank range.
// Input channel (in_valid / in_stall): one station per transfer, distances
// nondecreasing; in_last_station closes a set. Output channel (out_valid /
// out_stall): one result per set, min_total_cost and reachable, shown when
// the last station is done. Registers tank_range (0x0) and road_length
// (0x4) go over the APB-style port; the user must write them only while
// the block is idle, which the block itself does not enforce. Flow: the
// back engine takes a station through FETCH, FRONT, EVAL and BACK, with
// FRONT held for every front entry dropped as out of range and BACK
// for every dominated tail entry popped; both are bounded by one per
// station on average since each entry is pushed once. A station after a
// broken chain passes through FETCH alone. The deque memory has a
// registered read. A last station then moves to DONE to load the output
// register. A 4-entry station queue lets the input keep flowing meanwhile.
// Reset clears the registers and the per-set state and empties the deque;
// its memory keeps old contents, which are never read before being written.
// While out_stall holds, the result waits in the output register; the back
// engine stops only when the next result is ready.
module sliding_window_min_refuel_dp #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swmrd_pkg::ADDR_W-1:0]  paddr,
  input  logic [swmrd_pkg::DATA_W-1:0]  pwdata,
  output logic [swmrd_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swmrd_pkg::DIST_W-1:0]  in_station_distance,
  input  logic [swmrd_pkg::COST_W-1:0]  in_station_cost,
  input  logic                          in_last_station,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swmrd_pkg::TOTAL_W-1:0] out_min_total_cost,
  output logic                          out_reachable
);
  import swmrd_pkg::*;

  logic              fifo_full;
  logic              fifo_wr;
  item_t             wr_item;
  logic              fifo_rd;
  logic              fifo_valid;
  item_t             rd_item;
  logic [DIST_W-1:0] tank_range;
  logic [DIST_W-1:0] road_length;

  swmrd_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_station_distance (in_station_distance),
    .in_station_cost     (in_station_cost),
    .in_last_station     (in_last_station),
    .fifo_full           (fifo_full),
    .fifo_wr             (fifo_wr),
    .fifo_item           (wr_item),
    .tank_range          (tank_range),
    .road_length         (road_length)
  );

  swmrd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fifo_wr),
    .wr_item  (wr_item),
    .full     (fifo_full),
    .rd_en    (fifo_rd),
    .rd_valid (fifo_valid),
    .rd_item  (rd_item)
  );

  swmrd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .fifo_valid         (fifo_valid),
    .fifo_item          (rd_item),
    .fifo_rd            (fifo_rd),
    .tank_range         (tank_range),
    .road_length        (road_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_min_total_cost (out_min_total_cost),
    .out_reachable      (out_reachable)
  );

endmodule

@@ design/swmrd_front.sv @@
module swmrd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swmrd_pkg::ADDR_W-1:0]  paddr,
  input  logic [swmrd_pkg::DATA_W-1:0]  pwdata,
  output logic [swmrd_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swmrd_pkg::DIST_W-1:0]  in_station_distance,
  input  logic [swmrd_pkg::COST_W-1:0]  in_station_cost,
  input  logic                          in_last_station,
  input  logic                          fifo_full,
  output logic                          fifo_wr,
  output swmrd_pkg::item_t              fifo_item,
  output logic [swmrd_pkg::DIST_W-1:0]  tank_range,
  output logic [swmrd_pkg::DIST_W-1:0]  road_length
);
  import swmrd_pkg::*;

  logic [DIST_W-1:0] tank_range_r;
  logic [DIST_W-1:0] road_length_r;
  logic              cfg_wr;
  logic [DIST_W:0]   reach_sum;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tank_range_r  <= '0;
      road_length_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TANK_RANGE:  tank_range_r  <= pwdata;
        REG_ROAD_LENGTH: road_length_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TANK_RANGE:  prdata = tank_range_r;
      REG_ROAD_LENGTH: prdata = road_length_r;
      default:         prdata = '0;
    endcase
  end

  assign tank_range  = tank_range_r;
  assign road_length = road_length_r;

  // classify on the way into the queue
  assign reach_sum = {1'b0, in_station_distance} + {1'b0, tank_range_r};

  always_comb begin
    fifo_item.position   = in_station_distance;
    fifo_item.cost       = in_station_cost;
    fifo_item.last       = in_last_station;
    fifo_item.near_start = (in_station_distance <= tank_range_r);
    fifo_item.near_end   = (reach_sum >= {1'b0, road_length_r});
  end

  assign in_stall = fifo_full;
  assign fifo_wr  = in_valid & ~fifo_full;

endmodule

@@ design/swmrd_fifo.sv @@
module swmrd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  swmrd_pkg::item_t wr_item,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output swmrd_pkg::item_t rd_item
);
  import swmrd_pkg::*;

  item_t                 slots_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_wr;
  logic                  do_rd;

  assign full     = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = slots_r[rd_ptr_r];
  assign do_wr    = wr_en & ~full;
  assign do_rd    = rd_en & rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + FIFO_CNT_W'(1);
        2'b01:   count_r <= count_r - FIFO_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ design/swmrd_back.sv @@
module swmrd_back #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fifo_valid,
  input  swmrd_pkg::item_t              fifo_item,
  output logic                          fifo_rd,
  input  logic [swmrd_pkg::DIST_W-1:0]  tank_range,
  input  logic [swmrd_pkg::DIST_W-1:0]  road_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swmrd_pkg::TOTAL_W-1:0] out_min_total_cost,
  output logic                          out_reachable
);
  import swmrd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_FRONT,
    ST_EVAL,
    ST_BACK,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  item_t              cur_r, cur_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOTAL_W-1:0] best_r, best_nxt;
  logic               best_valid_r, best_valid_nxt;
  logic               broken_r, broken_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0] out_cost_r, out_cost_nxt;
  logic               out_reach_r, out_reach_nxt;

  logic [DIST_W-1:0]  mem_dist  [QUEUE_DEPTH];
  logic [TOTAL_W-1:0] mem_total [QUEUE_DEPTH];
  logic [DIST_W-1:0]  rd_dist_q;
  logic [TOTAL_W-1:0] rd_total_q;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   wr_addr;
  logic               wr_en;

  logic [DIST_W:0]    front_reach;
  logic               front_stale;
  logic [TOTAL_W-1:0] base_val;
  logic [TOTAL_W:0]   raw_sum;
  logic [TOTAL_W-1:0] sat_total;
  logic               is_full;

  // ring position of head plus an offset, offset at most the depth
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] head,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(off);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_dist[wr_addr]  <= cur_r.position;
      mem_total[wr_addr] <= total_r;
    end
    rd_dist_q  <= mem_dist[rd_addr];
    rd_total_q <= mem_total[rd_addr];
  end

  assign front_reach = {1'b0, rd_dist_q} + {1'b0, tank_range};
  assign front_stale = (count_r != '0) && (front_reach < {1'b0, cur_r.position});
  assign base_val    = cur_r.near_start ? '0 : rd_total_q;
  assign raw_sum     = {1'b0, base_val} + (TOTAL_W + 1)'(cur_r.cost);
  assign sat_total   = raw_sum[TOTAL_W] ? '1 : raw_sum[TOTAL_W-1:0];
  assign is_full     = (count_r >= CNT_W'(QUEUE_DEPTH));

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    best_nxt       = best_r;
    best_valid_nxt = best_valid_r;
    broken_nxt     = broken_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_cost_nxt   = out_cost_r;
    out_reach_nxt  = out_reach_r;
    fifo_rd        = 1'b0;
    rd_addr        = head_r;
    wr_en          = 1'b0;
    wr_addr        = slot(head_r, count_r);

    case (state_r)
      ST_FETCH: begin
        if (fifo_valid) begin
          fifo_rd = 1'b1;
          cur_nxt = fifo_item;
          if (broken_r) begin
            state_nxt = fifo_item.last ? ST_DONE : ST_FETCH;
          end else begin
            state_nxt = ST_FRONT;
          end
        end
      end
      ST_FRONT: begin
        if (front_stale) begin
          // drop the out-of-range front entry and look at the next one
          head_nxt  = slot(head_r, CNT_W'(1));
          count_nxt = count_r - CNT_W'(1);
          rd_addr   = slot(head_r, CNT_W'(1));
        end else begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!cur_r.near_start && count_r == '0) begin
          broken_nxt = 1'b1;
          state_nxt  = cur_r.last ? ST_DONE : ST_FETCH;
        end else begin
          total_nxt = sat_total;
          if (cur_r.near_end && (!best_valid_r || sat_total < best_r)) begin
            best_nxt       = sat_total;
            best_valid_nxt = 1'b1;
          end
          rd_addr   = slot(head_r, (count_r != '0) ? count_r - CNT_W'(1) : '0);
          state_nxt = ST_BACK;
        end
      end
      ST_BACK: begin
        if (count_r != '0 && rd_total_q >= total_r) begin
          // pop a dominated tail entry, fetch the new tail
          count_nxt = count_r - CNT_W'(1);
          rd_addr   = slot(head_r, (count_r >= CNT_W'(2)) ? count_r - CNT_W'(2) : '0);
        end else begin
          // when full, the write slot is the old head
          wr_en = 1'b1;
          if (is_full) begin
            head_nxt = slot(head_r, CNT_W'(1));
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = cur_r.last ? ST_DONE : ST_FETCH;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (tank_range >= road_length) begin
            out_cost_nxt  = '0;
            out_reach_nxt = 1'b1;
          end else begin
            out_cost_nxt  = best_valid_r ? best_r : '0;
            out_reach_nxt = best_valid_r;
          end
          head_nxt       = '0;
          count_nxt      = '0;
          best_nxt       = '0;
          best_valid_nxt = 1'b0;
          broken_nxt     = 1'b0;
          state_nxt      = ST_FETCH;
        end
      end
      default: state_nxt = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FETCH;
      head_r       <= '0;
      count_r      <= '0;
      best_r       <= '0;
      best_valid_r <= 1'b0;
      broken_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      best_r       <= best_nxt;
      best_valid_r <= best_valid_nxt;
      broken_r     <= broken_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cur_r       <= cur_nxt;
    total_r     <= total_nxt;
    out_cost_r  <= out_cost_nxt;
    out_reach_r <= out_reach_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_min_total_cost = out_cost_r;
  assign out_reachable      = out_reach_r;

endmodule
